@@ src/box_filter_3x3_edge_aware_macros.svh @@
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_AWARE_MACROS_SVH

// same-cycle implication
`define BF3EA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BF3EA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bf3ea_pkg.sv @@
// ----------------------------------------------------------------------------
// bf3ea_pkg
// Shared constants, types and the divide-by-count reciprocal table.
// ----------------------------------------------------------------------------
package bf3ea_pkg;

    localparam int MAX_WIDTH_DEF    = 32;
    localparam int IMAGE_SIZE_RESET = 32;
    localparam int PIX_W            = 8;
    localparam int SIZE_W           = 6;
    localparam int NUM_SLOTS        = 3;
    localparam int ACC_W            = 12;   // 9 * 255 fits
    localparam int RECIP_W          = 15;
    localparam int RECIP_SHIFT      = 16;

    typedef logic [1:0] t_div_sel;
    localparam t_div_sel DIV_4 = 2'd0;
    localparam t_div_sel DIV_6 = 2'd1;
    localparam t_div_sel DIV_9 = 2'd2;

    typedef logic [1:0] t_slot;

    typedef struct packed {
        logic                 wr_en;
        t_slot                wr_slot;
        logic                 rd_en;
        logic                 rd_colv;
        logic                 acc_clr;
        logic [NUM_SLOTS-1:0] row_mask;
        t_div_sel             div_sel;
        logic                 mul_en;
        logic                 load;
        logic                 image_done;
        logic                 run_end;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // floor(s/d) == (s * recip) >> 16 for s <= 2295
    function automatic logic [RECIP_W-1:0] div_recip(input t_div_sel sel);
        case (sel)
            DIV_4:   return RECIP_W'(16384);
            DIV_6:   return RECIP_W'(10923);
            DIV_9:   return RECIP_W'(7282);
            default: return RECIP_W'(16384);
        endcase
    endfunction

endpackage

@@ src/box_filter_3x3_edge_aware.sv @@
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware
// Flow: each result runs through reads of the left, center and right column and a drain,
//   a multiply, then a load into the output register, held while that register is full.
//   A new input beat is taken only once every result of the previous beat is loaded.
// Reset: position counters cleared, image size 32 (capped at MAX_WIDTH), output empty.
//   Row RAMs are not cleared; every read hits a pixel of the current image.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_aware #(
    parameter int MAX_WIDTH = bf3ea_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write: image size, restarts the image
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bf3ea_pkg::SIZE_W-1:0] i_cfg_image_size,
    // pixel input, raster order
    input  logic                         i_pix_valid,
    output logic                         o_pix_ready,
    input  logic [bf3ea_pkg::PIX_W-1:0]  i_pixel_in,
    // smoothed result output
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [bf3ea_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                         o_image_done,
    output logic                         o_run_end
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Results run one row behind the input. Pixel (r,c) with r,c >= 1 yields
    // result (r-1,c-1); at the last column also (r-1,N-1). The final pixel
    // of the image then flushes the whole last row. Row RAM slot = row mod 3.
    bf3ea_pkg::t_dp_cmd    cmd;
    bf3ea_pkg::t_dp_status status;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;

    bf3ea_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pix_valid      (i_pix_valid),
        .o_pix_ready      (o_pix_ready),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_image_size (i_cfg_image_size),
        .o_cmd            (cmd),
        .o_waddr          (waddr),
        .o_raddr          (raddr),
        .i_status         (status)
    );

    // window sum per column, divide by 4/6/9 via reciprocal multiply;
    // the output register lets a new pixel in while a result waits
    bf3ea_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_waddr      (waddr),
        .i_raddr      (raddr),
        .i_pixel      (i_pixel_in),
        .o_status     (status),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_pixel_out  (o_pixel_out),
        .o_image_done (o_image_done),
        .o_run_end    (o_run_end)
    );

endmodule

@@ src/bf3ea_ram.sv @@
// ----------------------------------------------------------------------------
// bf3ea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bf3ea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/bf3ea_dp.sv @@
// ----------------------------------------------------------------------------
// bf3ea_dp
// Datapath: three row RAMs, column accumulator, reciprocal multiply, out reg.
// ----------------------------------------------------------------------------
module bf3ea_dp #(
    parameter int MAX_WIDTH = bf3ea_pkg::MAX_WIDTH_DEF,
    localparam int AW       = $clog2(MAX_WIDTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bf3ea_pkg::t_dp_cmd          i_cmd,
    input  logic [AW-1:0]               i_waddr,
    input  logic [AW-1:0]               i_raddr,
    input  logic [bf3ea_pkg::PIX_W-1:0] i_pixel,
    output bf3ea_pkg::t_dp_status       o_status,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [bf3ea_pkg::PIX_W-1:0] o_pixel_out,
    output logic                        o_image_done,
    output logic                        o_run_end
);

    localparam int PIX_W  = bf3ea_pkg::PIX_W;
    localparam int ACC_W  = bf3ea_pkg::ACC_W;
    localparam int PROD_W = bf3ea_pkg::ACC_W + bf3ea_pkg::RECIP_W;
    localparam int COL_W  = PIX_W + 2;

    logic [PIX_W-1:0]  rd_data [bf3ea_pkg::NUM_SLOTS];
    logic [COL_W-1:0]  colsum;

    logic              r_rd_d;
    logic              r_colv_d;
    logic [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0] r_prod;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_done;
    logic              r_end;

    for (genvar g = 0; g < bf3ea_pkg::NUM_SLOTS; g++) begin : g_row
        bf3ea_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.wr_en && (i_cmd.wr_slot == bf3ea_pkg::t_slot'(g))),
            .i_waddr (i_waddr),
            .i_wdata (i_pixel),
            .i_raddr (i_raddr),
            .o_rdata (rd_data[g])
        );
    end

    // one column of the window, rows outside the image masked off
    always_comb begin
        colsum = '0;
        for (int s = 0; s < bf3ea_pkg::NUM_SLOTS; s++) begin
            if (i_cmd.row_mask[s]) begin
                colsum = colsum + COL_W'(rd_data[s]);
            end
        end
        if (!r_colv_d) begin
            colsum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_d      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_d <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_colv_d <= i_cmd.rd_colv;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_rd_d) begin
            r_acc <= r_acc + ACC_W'(colsum);
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(r_acc) * PROD_W'(bf3ea_pkg::div_recip(i_cmd.div_sel));
        end
        if (i_cmd.load) begin
            r_pixel <= r_prod[bf3ea_pkg::RECIP_SHIFT +: PIX_W];
            r_done  <= i_cmd.image_done;
            r_end   <= i_cmd.run_end;
        end
    end

    assign o_status.out_free = !r_out_valid || i_res_ready;
    assign o_res_valid       = r_out_valid;
    assign o_pixel_out       = r_pixel;
    assign o_image_done      = r_done;
    assign o_run_end         = r_end;

endmodule

@@ src/bf3ea_ctrl.sv @@
// ----------------------------------------------------------------------------
// bf3ea_ctrl
// Controller: position counters, result sequencing, window read schedule.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_edge_aware_macros.svh"

module bf3ea_ctrl #(
    parameter int MAX_WIDTH = bf3ea_pkg::MAX_WIDTH_DEF,
    localparam int AW       = $clog2(MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pix_valid,
    output logic                         o_pix_ready,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bf3ea_pkg::SIZE_W-1:0] i_cfg_image_size,
    output bf3ea_pkg::t_dp_cmd           o_cmd,
    output logic [AW-1:0]                o_waddr,
    output logic [AW-1:0]                o_raddr,
    input  bf3ea_pkg::t_dp_status        i_status
);

    localparam int NW      = $clog2(MAX_WIDTH + 1);
    localparam int RESET_N = (bf3ea_pkg::IMAGE_SIZE_RESET > MAX_WIDTH) ?
                             MAX_WIDTH : bf3ea_pkg::IMAGE_SIZE_RESET;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // read phase: left, center, right column, then drain
    localparam logic [1:0] K_PREV = 2'd0;
    localparam logic [1:0] K_MID  = 2'd1;
    localparam logic [1:0] K_NEXT = 2'd2;
    localparam logic [1:0] K_LAST = 2'd3;

    function automatic bf3ea_pkg::t_slot slot_inc(input bf3ea_pkg::t_slot s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic bf3ea_pkg::t_slot slot_dec(input bf3ea_pkg::t_slot s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    logic [1:0]           r_state, n_state;
    logic [1:0]           r_k, n_k;
    logic [NW-1:0]        r_n;
    logic [AW-1:0]        r_row;
    logic [AW-1:0]        r_col;
    bf3ea_pkg::t_slot     r_slot;
    logic [AW-1:0]        r_in_row;
    logic [AW-1:0]        r_in_col;
    bf3ea_pkg::t_slot     r_in_slot;
    logic                 r_in_last;
    logic [AW-1:0]        r_jcol, n_jcol;
    logic                 r_jflush, n_jflush;

    logic [NW-1:0]        cfg_n;
    logic [AW-1:0]        nm1;
    logic [AW-1:0]        nm2;
    logic                 pix_acc;
    logic                 cfg_acc;
    logic                 in_last;
    logic                 has_first;
    logic                 more_b;
    logic                 start_flush;
    logic                 cont_flush;
    logic                 rows3;
    logic                 cols3;

    assign nm1       = AW'(r_n - NW'(1));
    assign nm2       = AW'(r_n - NW'(2));
    assign o_pix_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign pix_acc   = i_pix_valid && o_pix_ready;
    assign cfg_acc   = i_cfg_valid;
    assign in_last   = (r_row == nm1) && (r_col == nm1);
    assign has_first = (r_row != '0) && (r_col != '0);

    // clamp written size to [2, MAX_WIDTH]
    always_comb begin
        if (int'(i_cfg_image_size) < 2) begin
            cfg_n = NW'(2);
        end else if (int'(i_cfg_image_size) > MAX_WIDTH) begin
            cfg_n = NW'(MAX_WIDTH);
        end else begin
            cfg_n = NW'(i_cfg_image_size);
        end
    end

    // what follows the current result for this input beat
    assign more_b      = !r_jflush && (r_in_col == nm1) && (r_jcol == nm2);
    assign start_flush = !r_jflush && !more_b && r_in_last;
    assign cont_flush  = r_jflush && (r_jcol != nm1);
    assign rows3       = !r_jflush && (r_in_row > AW'(1));
    assign cols3       = (r_jcol != '0) && (r_jcol != nm1);

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_jcol   = r_jcol;
        n_jflush = r_jflush;
        case (r_state)
            S_IDLE: begin
                if (pix_acc && has_first) begin
                    n_state  = S_RD;
                    n_k      = K_PREV;
                    n_jcol   = r_col - AW'(1);
                    n_jflush = 1'b0;
                end
            end
            S_RD: begin
                if (r_k == K_LAST) begin
                    n_state = S_MUL;
                end
                n_k = r_k + 2'd1;
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_k = K_PREV;
                    if (more_b) begin
                        n_state = S_RD;
                        n_jcol  = nm1;
                    end else if (start_flush) begin
                        n_state  = S_RD;
                        n_jflush = 1'b1;
                        n_jcol   = '0;
                    end else if (cont_flush) begin
                        n_state = S_RD;
                        n_jcol  = r_jcol + AW'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_raddr        = r_jcol;
        o_cmd.wr_en    = pix_acc;
        o_cmd.wr_slot  = r_slot;
        o_cmd.rd_en    = (r_state == S_RD) && (r_k != K_LAST);
        o_cmd.acc_clr  = (r_state == S_RD) && (r_k == K_PREV);
        o_cmd.mul_en   = (r_state == S_MUL);
        o_cmd.load     = (r_state == S_OUT) && i_status.out_free;
        o_cmd.image_done = r_jflush && (r_jcol == nm1);
        o_cmd.run_end  = !(more_b || start_flush || cont_flush);
        case (r_k)
            K_PREV: begin
                o_cmd.rd_colv = (r_jcol != '0);
                if (r_jcol != '0) begin
                    o_raddr = r_jcol - AW'(1);
                end
            end
            K_MID: begin
                o_cmd.rd_colv = 1'b1;
            end
            K_NEXT: begin
                o_cmd.rd_colv = (r_jcol != nm1);
                if (r_jcol != nm1) begin
                    o_raddr = r_jcol + AW'(1);
                end
            end
            default: begin
                o_cmd.rd_colv = 1'b0;
            end
        endcase
        // own row and the one above are always inside; the third only mid-image
        o_cmd.row_mask[r_in_slot]           = 1'b1;
        o_cmd.row_mask[slot_dec(r_in_slot)] = 1'b1;
        o_cmd.row_mask[slot_inc(r_in_slot)] = rows3;
        if (rows3 && cols3) begin
            o_cmd.div_sel = bf3ea_pkg::DIV_9;
        end else if (rows3 || cols3) begin
            o_cmd.div_sel = bf3ea_pkg::DIV_6;
        end else begin
            o_cmd.div_sel = bf3ea_pkg::DIV_4;
        end
    end

    assign o_waddr = r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= K_PREV;
            r_n     <= NW'(RESET_N);
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (cfg_acc) begin
                r_n    <= cfg_n;
                r_row  <= '0;
                r_col  <= '0;
                r_slot <= '0;
            end else if (pix_acc) begin
                if (r_col == nm1) begin
                    r_col <= '0;
                    if (r_row == nm1) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + AW'(1);
                        r_slot <= slot_inc(r_slot);
                    end
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_jcol   <= n_jcol;
        r_jflush <= n_jflush;
        if (pix_acc) begin
            r_in_row  <= r_row;
            r_in_col  <= r_col;
            r_in_slot <= r_slot;
            r_in_last <= in_last;
        end
    end

    `BF3EA_ASSERT_NXT(a_rd_then_mul, (r_state == S_RD && r_k == K_LAST), (r_state == S_MUL), "read phase did not end in multiply")
    `BF3EA_ASSERT_IMP(a_load_free, o_cmd.load, i_status.out_free, "result loaded over a pending beat")
    `BF3EA_ASSERT_IMP(a_done_ends_run, (o_cmd.load && o_cmd.image_done), o_cmd.run_end, "image end not marked as run end")
    `BF3EA_ASSERT_IMP(a_pos_range, 1'b1, (r_row <= nm1 && r_col <= nm1), "position counter beyond image")

endmodule

@@ bench/box_filter_3x3_edge_aware_checker.sv @@
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware_checker
// Watches the size, pixel and result channels of the 3x3 edge-aware mean
// filter. It keeps its own row store and raster position, predicts every
// smoothed pixel and compares the result beats in order.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_aware_checker #(
    parameter int MAX_W = bf3ea_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [bf3ea_pkg::SIZE_W-1:0] i_cfg_image_size,
    input  logic                         i_pix_valid,
    input  logic                         i_pix_ready,
    input  logic [bf3ea_pkg::PIX_W-1:0]  i_pixel_in,
    input  logic                         i_res_valid,
    input  logic                         i_res_ready,
    input  logic [bf3ea_pkg::PIX_W-1:0]  i_pixel_out,
    input  logic                         i_image_done,
    input  logic                         i_run_end,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W       = bf3ea_pkg::PIX_W;
    localparam int SIZE_W      = bf3ea_pkg::SIZE_W;
    localparam int NUM_SLOTS   = bf3ea_pkg::NUM_SLOTS;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             image_done;
        logic             run_end;
    } t_smoothed;

    logic [PIX_W-1:0]  rows [NUM_SLOTS][MAX_W];
    logic [SIZE_W-1:0] size_reg;
    int                row_pos;
    int                col_pos;
    t_smoothed         smoothed_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        size_reg     = SIZE_W'(bf3ea_pkg::IMAGE_SIZE_RESET);
        row_pos      = 0;
        col_pos      = 0;
    end

    function automatic int active_size();
        int n;
        n = int'(size_reg);
        if (n < 2) n = 2;
        if (n > MAX_W) n = MAX_W;
        return n;
    endfunction

    // floor of the mean over the neighbors that lie inside the image
    function automatic t_smoothed smoothed_at(input int r, input int c, input int n);
        t_smoothed s;
        int        sum;
        int        cnt;
        sum = 0;
        cnt = 0;
        for (int x = r - 1; x <= r + 1; x++) begin
            for (int y = c - 1; y <= c + 1; y++) begin
                if (x >= 0 && x < n && y >= 0 && y < n) begin
                    sum += int'(rows[x % NUM_SLOTS][y]);
                    cnt++;
                end
            end
        end
        s.pixel      = PIX_W'(sum / cnt);
        s.image_done = (r == n - 1 && c == n - 1);
        s.run_end    = 1'b0;
        return s;
    endfunction

    task automatic predict_pixel(input logic [PIX_W-1:0] value);
        int        n;
        int        r;
        int        c;
        t_smoothed batch [$];
        n = active_size();
        r = (row_pos >= n) ? n - 1 : row_pos;
        c = (col_pos >= n) ? n - 1 : col_pos;
        rows[r % NUM_SLOTS][c] = value;
        // one row behind: left neighbor done, plus the right edge at row end
        if (r >= 1) begin
            if (c >= 1) batch.push_back(smoothed_at(r - 1, c - 1, n));
            if (c == n - 1) batch.push_back(smoothed_at(r - 1, n - 1, n));
        end
        // last pixel flushes the bottom row
        if (r == n - 1 && c == n - 1) begin
            for (int j = 0; j < n; j++) batch.push_back(smoothed_at(n - 1, j, n));
        end
        if (batch.size() > 0) batch[batch.size() - 1].run_end = 1'b1;
        foreach (batch[i]) smoothed_q.push_back(batch[i]);
        if (c + 1 >= n) begin
            col_pos = 0;
            row_pos = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic check_result();
        t_smoothed want;
        if (smoothed_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= MAX_REPORTS)
                $display("%0t: unexpected beat: pixel_out=%0d image_done=%0d run_end=%0d",
                         $realtime, i_pixel_out, i_image_done, i_run_end);
        end else begin
            want = smoothed_q.pop_front();
            if (want.pixel !== i_pixel_out || want.image_done !== i_image_done ||
                want.run_end !== i_run_end) begin
                o_fail_count++;
                if (o_fail_count <= MAX_REPORTS)
                    $display("%0t: expected pix=%0d done=%0d end=%0d, got pix=%0d done=%0d end=%0d",
                             $realtime, want.pixel, want.image_done, want.run_end,
                             i_pixel_out, i_image_done, i_run_end);
            end
        end
    endtask

    // Sample mid-cycle: inputs only move at the rising edge, so what is seen
    // here is what the next rising edge accepts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            size_reg = SIZE_W'(bf3ea_pkg::IMAGE_SIZE_RESET);
            row_pos  = 0;
            col_pos  = 0;
            smoothed_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                size_reg = i_cfg_image_size;
                row_pos  = 0;
                col_pos  = 0;
            end
            if (i_pix_valid && i_pix_ready) predict_pixel(i_pixel_in);
        end
        o_pending = smoothed_q.size();
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top level for the 3x3 edge-aware mean filter. Drives size writes and pixel
// beats in bursts against a receiver with its own stall pattern; a checker
// beside the block predicts and compares every smoothed pixel.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W         = bf3ea_pkg::PIX_W;
    localparam int SIZE_W        = bf3ea_pkg::SIZE_W;
    localparam int MAX_W         = bf3ea_pkg::MAX_WIDTH_DEF;

    // Worst case is far below this: a few hundred pixels, at most 34 results
    // per pixel, plus receiver stalls, gaps and drains.
    localparam int CYCLE_LIMIT   = 600000;
    // random part; the directed part adds about 25 more
    localparam int RANDOM_PIXELS = 245;
    // A pixel with no result may still be in flight when the last expected beat shows up.
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 300;

    typedef enum int {
        RX_OPEN,      // always ready
        RX_COIN,      // random every cycle
        RX_PERIODIC,  // fixed duty pattern
        RX_TRICKLE    // mostly stalled
    } t_rx_mode;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [SIZE_W-1:0]    i_cfg_image_size = '0;
    logic                 i_pix_valid      = 1'b0;
    logic                 o_pix_ready;
    logic [PIX_W-1:0]     i_pixel_in       = '0;
    logic                 o_res_valid;
    logic                 i_res_ready      = 1'b0;
    logic [PIX_W-1:0]     o_pixel_out;
    logic                 o_image_done;
    logic                 o_run_end;

    int                   fail_count;
    int                   pending;
    int                   cycles           = 0;

    // sender state
    bit                   pix_live         = 1'b0;
    int                   burst_left       = 8;
    // long receiver hold-off handshake
    bit                   hold_req         = 1'b0;
    bit                   hold_done        = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    box_filter_3x3_edge_aware u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_image_size (i_cfg_image_size),
        .i_pix_valid      (i_pix_valid),
        .o_pix_ready      (o_pix_ready),
        .i_pixel_in       (i_pixel_in),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_pixel_out      (o_pixel_out),
        .o_image_done     (o_image_done),
        .o_run_end        (o_run_end)
    );

    box_filter_3x3_edge_aware_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_image_size (i_cfg_image_size),
        .i_pix_valid      (i_pix_valid),
        .i_pix_ready      (o_pix_ready),
        .i_pixel_in       (i_pixel_in),
        .i_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .i_pixel_out      (o_pixel_out),
        .i_image_done     (o_image_done),
        .i_run_end        (o_run_end),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL box_filter_3x3_edge_aware");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: switches between stall patterns, each held for a random stretch.
    // Once the stimulus asks, it holds ready low for a long counted stretch
    // so the block backs up and stalls its pixel input.
    // ------------------------------------------------------------------------
    initial begin
        t_rx_mode mode;
        int       span;
        int       tick;
        mode = RX_OPEN;
        span = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_res_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (span == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    span = $urandom_range(16, 96);
                end
                span--;
                tick++;
                case (mode)
                    RX_OPEN:     i_res_ready <= 1'b1;
                    RX_COIN:     i_res_ready <= ($urandom_range(0, 1) == 1);
                    RX_PERIODIC: i_res_ready <= (tick % 5) >= 2;
                    default:     i_res_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel side helpers
    // ------------------------------------------------------------------------

    // Drop valid if a beat is still being offered; called right after an edge.
    task automatic pix_release();
        if (pix_live) begin
            i_pix_valid <= 1'b0;
            pix_live = 1'b0;
        end
    endtask

    // One pixel beat. Valid stays up across a burst; at the end of a burst
    // the sender goes quiet for a random gap, then starts a new burst.
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        i_pix_valid <= 1'b1;
        i_pixel_in  <= value;
        pix_live = 1'b1;
        do @(negedge i_clk); while (!o_pix_ready);
        @(posedge i_clk);
        if (burst_left == 0) begin
            pix_release();
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Stop offering and wait until every predicted result beat has left.
    task automatic drain_results();
        pix_release();
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Size write; only issued once the block is drained.
    task automatic write_size(input logic [SIZE_W-1:0] size_val);
        drain_results();
        i_cfg_valid      <= 1'b1;
        i_cfg_image_size <= size_val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Pixel value, biased toward the extremes so sums hit their bounds.
    function automatic logic [PIX_W-1:0] pick_pixel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic int clamp_size(input int v);
        if (v < 2) return 2;
        if (v > MAX_W) return MAX_W;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin
        int size_val;
        int n;
        int count;
        int pause_at;
        int sent;
        int phase;
        int roll;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset size, first row only -> no results expected
        send_pixel('0);
        send_pixel('1);

        // 2x2 image (restart mid-image), then a second image to check wrap
        write_size(SIZE_W'(2));
        send_pixel('1);
        send_pixel('0);
        send_pixel('0);
        send_pixel('1);
        repeat (4) send_pixel('1);

        // below-range size acts as 2
        write_size(SIZE_W'(1));
        repeat (4) send_pixel('0);

        // zero size, abandoned after three pixels
        write_size('0);
        send_pixel('1);
        send_pixel('1);
        send_pixel('0);

        // 3x3, cut off inside the second row
        write_size(SIZE_W'(3));
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
        send_pixel('1);
        send_pixel('0);

        // all-ones size code clamps to the maximum width
        write_size('1);
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);

        // Random part: mostly whole small images with random content, some
        // cut short, a few large partial images and a few out-of-range codes.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            if (phase == 0) begin
                size_val = 8;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 65)      size_val = $urandom_range(2, 6);
                else if (roll < 88) size_val = $urandom_range(7, 12);
                else if (roll < 94) size_val = $urandom_range(13, 63);
                else                size_val = $urandom_range(0, 1);
            end
            n = clamp_size(size_val);
            if (n > 12) begin
                count = $urandom_range(n, 2 * n + 2);
            end else begin
                count = (phase == 0) ? n * n : $urandom_range(1, 2) * n * n;
                if (phase != 0 && $urandom_range(0, 3) == 0)
                    count = $urandom_range(1, n * n - 1);
            end
            // keep the total close to the pixel budget
            if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;
            // skipping the write now and then lets the next image follow on
            if (phase < 2 || $urandom_range(0, 4) != 0)
                write_size(SIZE_W'(size_val));
            else
                drain_results();
            // first image runs into a long receiver hold-off
            if (phase == 0) hold_req = 1'b1;
            pause_at = (phase == 1 || $urandom_range(0, 3) == 0)
                       ? $urandom_range(0, count - 1) : -1;
            for (int i = 0; i < count; i++) begin
                if (i == pause_at) drain_results();
                send_pixel(pick_pixel());
                sent++;
            end
            phase++;
        end

        drain_results();

        if (fail_count == 0 && pending == 0) begin
            $display("PASS box_filter_3x3_edge_aware");
        end else begin
            $display("FAIL box_filter_3x3_edge_aware");
        end
        $finish;
    end

endmodule
